>>> design/sbs_pkg.sv
// shared types and constants for the sparse bitset set-operation block
`default_nettype none

package sbs_pkg;

   localparam int OpW            = 3;
   localparam int RankFieldW     = 16;
   localparam int WordW          = 64;
   localparam int DefMaxGranules = 16;
   localparam int DefRankWidth   = 16;
   localparam int CmdDepth       = 2;
   localparam int RspDepth       = 2;

   typedef enum logic [OpW-1:0] {
      OP_LOAD_A    = 3'd0,
      OP_LOAD_B    = 3'd1,
      OP_OR        = 3'd2,
      OP_XOR       = 3'd3,
      OP_AND       = 3'd4,
      OP_AND_NOT   = 3'd5,
      OP_CONTAIN   = 3'd6,
      OP_INTERSECT = 3'd7
   } op_type;

   typedef struct packed {
      logic done;
      logic bank;
   } back_stat_type;

   typedef struct packed {
      logic [RankFieldW-1:0] out_rank;
      logic [WordW-1:0]      out_word;
      logic                  answer;
      logic                  empty_res;
      logic                  overflow;
      logic                  last;
   } rsp_item_type;

endpackage

`default_nettype wire

>>> design/sbs_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module sbs_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/sbs_fifo.sv
// small register fifo used for the command queue and the result queue
`default_nettype none

module sbs_fifo #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 2,
   localparam int PtrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CntW  = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push & ~full;
   assign pop_ok   = pop & ~empty;
   assign pop_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      case ({push_ok, pop_ok})
         2'b10:   count_in = count_ff + CntW'(1);
         2'b01:   count_in = count_ff - CntW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> design/sbs_front.sv
// front end: takes requests, stores granules, queues run commands
`default_nettype none

module sbs_front #(
   parameter  int MAX_GRANULES = sbs_pkg::DefMaxGranules,
   parameter  int RANK_WIDTH   = sbs_pkg::DefRankWidth,
   localparam int SRW    = (RANK_WIDTH < sbs_pkg::RankFieldW) ? RANK_WIDTH : sbs_pkg::RankFieldW,
   localparam int EntryW = SRW + sbs_pkg::WordW,
   localparam int CntW   = $clog2(MAX_GRANULES + 1),
   localparam int IdxW   = (MAX_GRANULES > 1) ? $clog2(MAX_GRANULES) : 1,
   localparam int AddrW  = $clog2(2 * MAX_GRANULES),
   localparam int CmdW   = sbs_pkg::OpW + 2 + 2 * CntW
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic [sbs_pkg::OpW-1:0]         req_op,
   input  wire logic [sbs_pkg::RankFieldW-1:0]  req_granule_rank,
   input  wire logic [sbs_pkg::WordW-1:0]       req_granule_word,
   output logic                                 a_we,
   output logic                                 b_we,
   output logic      [AddrW-1:0]                wr_addr,
   output logic      [EntryW-1:0]               wr_data,
   output logic                                 cmd_push,
   output logic      [CmdW-1:0]                 cmd_data,
   input  wire logic                            cmd_full,
   input  wire sbs_pkg::back_stat_type          back_stat
);

   import sbs_pkg::*;

   typedef struct packed {
      op_type          op;
      logic            bank;
      logic [CntW-1:0] a_cnt;
      logic [CntW-1:0] b_cnt;
      logic            ovf;
   } cmd_type;

   logic [1:0]      busy_ff, busy_in;
   logic            bank_ff, bank_in;
   logic [CntW-1:0] a_cnt_ff, a_cnt_in;
   logic [CntW-1:0] b_cnt_ff, b_cnt_in;
   logic            drop_ff, drop_in;
   logic            accept;
   logic            word_nz;
   op_type          op;
   logic [AddrW-1:0] bank_base;
   cmd_type         cmd;

   assign op        = op_type'(req_op);
   assign req_full  = busy_ff[bank_ff] | cmd_full;
   assign accept    = req_push & ~req_full;
   assign word_nz   = |req_granule_word;
   assign bank_base = bank_ff ? AddrW'(MAX_GRANULES) : '0;
   assign wr_data   = {req_granule_rank[SRW-1:0], req_granule_word};

   assign cmd.op    = op;
   assign cmd.bank  = bank_ff;
   assign cmd.a_cnt = a_cnt_ff;
   assign cmd.b_cnt = b_cnt_ff;
   assign cmd.ovf   = drop_ff;
   assign cmd_data  = cmd;

   always_comb begin
      busy_in  = busy_ff;
      bank_in  = bank_ff;
      a_cnt_in = a_cnt_ff;
      b_cnt_in = b_cnt_ff;
      drop_in  = drop_ff;
      a_we     = 1'b0;
      b_we     = 1'b0;
      cmd_push = 1'b0;
      wr_addr  = bank_base + AddrW'(a_cnt_ff[IdxW-1:0]);
      if (back_stat.done) begin
         busy_in[back_stat.bank] = 1'b0;
      end
      if (accept) begin
         unique case (op) inside
            OP_LOAD_A: begin
               if (word_nz) begin
                  if (a_cnt_ff < CntW'(MAX_GRANULES)) begin
                     a_we     = 1'b1;
                     a_cnt_in = a_cnt_ff + CntW'(1);
                  end else begin
                     drop_in = 1'b1;
                  end
               end
            end
            OP_LOAD_B: begin
               wr_addr = bank_base + AddrW'(b_cnt_ff[IdxW-1:0]);
               if (word_nz) begin
                  if (b_cnt_ff < CntW'(MAX_GRANULES)) begin
                     b_we     = 1'b1;
                     b_cnt_in = b_cnt_ff + CntW'(1);
                  end else begin
                     drop_in = 1'b1;
                  end
               end
            end
            OP_OR, OP_XOR, OP_AND, OP_AND_NOT, OP_CONTAIN, OP_INTERSECT: begin
               cmd_push         = 1'b1;
               busy_in[bank_ff] = 1'b1;
               bank_in          = ~bank_ff;
               a_cnt_in         = '0;
               b_cnt_in         = '0;
               drop_in          = 1'b0;
            end
            default: begin
               cmd_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= '0;
         bank_ff  <= 1'b0;
         a_cnt_ff <= '0;
         b_cnt_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         bank_ff  <= bank_in;
         a_cnt_ff <= a_cnt_in;
         b_cnt_ff <= b_cnt_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

`default_nettype wire

>>> design/sbs_back.sv
// back end: merge walk over both granule lists, one step per cycle while the result queue has room
`default_nettype none

module sbs_back #(
   parameter  int MAX_GRANULES = sbs_pkg::DefMaxGranules,
   parameter  int RANK_WIDTH   = sbs_pkg::DefRankWidth,
   localparam int SRW    = (RANK_WIDTH < sbs_pkg::RankFieldW) ? RANK_WIDTH : sbs_pkg::RankFieldW,
   localparam int EntryW = SRW + sbs_pkg::WordW,
   localparam int CntW   = $clog2(MAX_GRANULES + 1),
   localparam int IdxW   = (MAX_GRANULES > 1) ? $clog2(MAX_GRANULES) : 1,
   localparam int AddrW  = $clog2(2 * MAX_GRANULES),
   localparam int CmdW   = sbs_pkg::OpW + 2 + 2 * CntW
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   cmd_empty,
   output logic                        cmd_pop,
   input  wire logic [CmdW-1:0]        cmd_data,
   output logic      [AddrW-1:0]       a_rd_addr,
   output logic      [AddrW-1:0]       b_rd_addr,
   input  wire logic [EntryW-1:0]      a_q,
   input  wire logic [EntryW-1:0]      b_q,
   output logic                        rsp_push,
   output sbs_pkg::rsp_item_type       rsp_item,
   input  wire logic                   rsp_full,
   output sbs_pkg::back_stat_type      back_stat
);

   import sbs_pkg::*;

   typedef struct packed {
      op_type          op;
      logic            bank;
      logic [CntW-1:0] a_cnt;
      logic [CntW-1:0] b_cnt;
      logic            ovf;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in, cmd_head;
   logic [CntW-1:0]  i_ff, i_in, j_ff, j_in;
   logic [SRW-1:0]   held_rank_ff, held_rank_in;
   logic [WordW-1:0] held_word_ff, held_word_in;
   logic             held_vld_ff, held_vld_in;
   logic [SRW-1:0]   ar, br, cand_rank;
   logic [WordW-1:0] aw, bw, cand_word, pair_word;
   logic             a_v, b_v, lt, gt;
   logic             keep_a, keep_b, is_query;
   logic             cand, done, ans, step_i, step_j;
   logic [IdxW-1:0]  a_idx, b_idx;
   logic [AddrW-1:0] rd_base;

   assign cmd_head = cmd_type'(cmd_data);
   assign {ar, aw} = a_q;
   assign {br, bw} = b_q;
   assign a_v      = i_ff < cmd_ff.a_cnt;
   assign b_v      = j_ff < cmd_ff.b_cnt;
   assign lt       = ar < br;
   assign gt       = ar > br;
   assign keep_a   = (cmd_ff.op == OP_OR) || (cmd_ff.op == OP_XOR) || (cmd_ff.op == OP_AND_NOT);
   assign keep_b   = (cmd_ff.op == OP_OR) || (cmd_ff.op == OP_XOR);
   assign is_query = (cmd_ff.op == OP_CONTAIN) || (cmd_ff.op == OP_INTERSECT);

   // read the entries that the next cycle will compare
   assign a_idx     = (i_in < CntW'(MAX_GRANULES)) ? i_in[IdxW-1:0] : '0;
   assign b_idx     = (j_in < CntW'(MAX_GRANULES)) ? j_in[IdxW-1:0] : '0;
   assign rd_base   = cmd_in.bank ? AddrW'(MAX_GRANULES) : '0;
   assign a_rd_addr = rd_base + AddrW'(a_idx);
   assign b_rd_addr = rd_base + AddrW'(b_idx);

   always_comb begin
      unique case (cmd_ff.op) inside
         OP_OR:   pair_word = aw | bw;
         OP_XOR:  pair_word = aw ^ bw;
         OP_AND:  pair_word = aw & bw;
         default: pair_word = aw & ~bw;
      endcase
   end

   // one merge step
   always_comb begin
      cand      = 1'b0;
      cand_rank = ar;
      cand_word = aw;
      step_i    = 1'b0;
      step_j    = 1'b0;
      done      = 1'b0;
      ans       = 1'b0;
      unique case (cmd_ff.op) inside
         OP_CONTAIN: begin
            if (!b_v) begin
               done = 1'b1;
               ans  = 1'b1;
            end else if (!a_v || gt) begin
               done = 1'b1;
            end else if (lt) begin
               step_i = 1'b1;
            end else if ((aw & bw) != bw) begin
               done = 1'b1;
            end else begin
               step_i = 1'b1;
               step_j = 1'b1;
            end
         end
         OP_INTERSECT: begin
            if (!(a_v && b_v)) begin
               done = 1'b1;
            end else if (gt) begin
               step_j = 1'b1;
            end else if (lt) begin
               step_i = 1'b1;
            end else if (|(aw & bw)) begin
               done = 1'b1;
               ans  = 1'b1;
            end else begin
               step_i = 1'b1;
               step_j = 1'b1;
            end
         end
         OP_OR, OP_XOR, OP_AND, OP_AND_NOT: begin
            if (a_v && b_v) begin
               if (lt) begin
                  cand   = keep_a;
                  step_i = 1'b1;
               end else if (gt) begin
                  cand      = keep_b;
                  cand_rank = br;
                  cand_word = bw;
                  step_j    = 1'b1;
               end else begin
                  cand      = 1'b1;
                  cand_word = pair_word;
                  step_i    = 1'b1;
                  step_j    = 1'b1;
               end
            end else if (a_v && keep_a) begin
               cand   = 1'b1;
               step_i = 1'b1;
            end else if (b_v && keep_b) begin
               cand      = 1'b1;
               cand_rank = br;
               cand_word = bw;
               step_j    = 1'b1;
            end else begin
               done = 1'b1;
            end
         end
         default: begin
            done = 1'b1;
         end
      endcase
   end

   // sequencer; the newest granule is held back so the final one can carry last
   always_comb begin
      state_in          = state_ff;
      cmd_in            = cmd_ff;
      i_in              = i_ff;
      j_in              = j_ff;
      held_rank_in      = held_rank_ff;
      held_word_in      = held_word_ff;
      held_vld_in       = held_vld_ff;
      cmd_pop           = 1'b0;
      rsp_push          = 1'b0;
      rsp_item          = '0;
      rsp_item.overflow = cmd_ff.ovf;
      back_stat         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop     = 1'b1;
               cmd_in      = cmd_head;
               i_in        = '0;
               j_in        = '0;
               held_vld_in = 1'b0;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!rsp_full) begin
               if (step_i) begin
                  i_in = i_ff + CntW'(1);
               end
               if (step_j) begin
                  j_in = j_ff + CntW'(1);
               end
               if (done) begin
                  rsp_push       = 1'b1;
                  rsp_item.last  = 1'b1;
                  back_stat.done = 1'b1;
                  back_stat.bank = cmd_ff.bank;
                  held_vld_in    = 1'b0;
                  state_in       = ST_IDLE;
                  if (is_query) begin
                     rsp_item.answer = ans;
                  end else if (held_vld_ff) begin
                     rsp_item.out_rank = RankFieldW'(held_rank_ff);
                     rsp_item.out_word = held_word_ff;
                  end else begin
                     rsp_item.empty_res = 1'b1;
                  end
               end else if (cand && (|cand_word)) begin
                  rsp_push          = held_vld_ff;
                  rsp_item.out_rank = RankFieldW'(held_rank_ff);
                  rsp_item.out_word = held_word_ff;
                  held_rank_in      = cand_rank;
                  held_word_in      = cand_word;
                  held_vld_in       = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         held_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         held_vld_ff <= held_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      held_rank_ff <= held_rank_in;
      held_word_ff <= held_word_in;
   end

endmodule

`default_nettype wire

>>> design/sparse_bitset_set_ops.sv
// top level of the sparse bitset set-operation block
//
// requests come in on a queue-style port: an item is taken when req_push is
// high and req_full is low. load A / load B requests store one nonzero granule
// in a cycle, back to back. a run request (or, xor, and, and-not, contain,
// intersect) closes the current pair of sets and goes into a short command
// queue; the granule store has two banks, so loads for the next run are
// taken while the merge of the previous run is still going on.
// the merge engine takes one step per cycle while the result queue has room;
// the ram read overlaps with taking the command. req_full rises only when the
// bank to be loaded still belongs to a run that is not done.
// results leave through a two-entry queue: while rsp_empty is low the oldest
// result sits on the rsp_ ports and is taken when rsp_pop is high. when that
// queue is full the merge holds its place and resumes when space frees up.
// reset clears all counts and queues; stored granules are not cleared and are
// never read before being written.
`default_nettype none

module sparse_bitset_set_ops #(
   parameter int MAX_GRANULES = sbs_pkg::DefMaxGranules,
   parameter int RANK_WIDTH   = sbs_pkg::DefRankWidth
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic [sbs_pkg::OpW-1:0]        req_op,
   input  wire logic [sbs_pkg::RankFieldW-1:0] req_granule_rank,
   input  wire logic [sbs_pkg::WordW-1:0]      req_granule_word,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic      [sbs_pkg::RankFieldW-1:0] rsp_out_rank,
   output logic      [sbs_pkg::WordW-1:0]      rsp_out_word,
   output logic                                rsp_answer,
   output logic                                rsp_empty_res,
   output logic                                rsp_overflow,
   output logic                                rsp_last
);

   import sbs_pkg::*;

   localparam int SRW    = (RANK_WIDTH < RankFieldW) ? RANK_WIDTH : RankFieldW;
   localparam int EntryW = SRW + WordW;
   localparam int CntW   = $clog2(MAX_GRANULES + 1);
   localparam int AddrW  = $clog2(2 * MAX_GRANULES);
   localparam int CmdW   = OpW + 2 + 2 * CntW;
   localparam int RspW   = $bits(rsp_item_type);

   logic                a_we, b_we;
   logic [AddrW-1:0]    wr_addr, a_rd_addr, b_rd_addr;
   logic [EntryW-1:0]   wr_data, a_q, b_q;
   logic                cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic [CmdW-1:0]     cmd_wdata, cmd_rdata;
   logic                rsp_push, rsp_full;
   rsp_item_type        rsp_item, rsp_head;
   logic [RspW-1:0]     rsp_head_bits;
   back_stat_type       back_stat;

   sbs_front #(
      .MAX_GRANULES (MAX_GRANULES),
      .RANK_WIDTH   (RANK_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_op           (req_op),
      .req_granule_rank (req_granule_rank),
      .req_granule_word (req_granule_word),
      .a_we             (a_we),
      .b_we             (b_we),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_wdata),
      .cmd_full         (cmd_full),
      .back_stat        (back_stat)
   );

   sbs_ram #(
      .WIDTH (EntryW),
      .DEPTH (2 * MAX_GRANULES)
   ) u_ram_a (
      .clock   (clock),
      .we      (a_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (a_rd_addr),
      .rd_data (a_q)
   );

   sbs_ram #(
      .WIDTH (EntryW),
      .DEPTH (2 * MAX_GRANULES)
   ) u_ram_b (
      .clock   (clock),
      .we      (b_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (b_rd_addr),
      .rd_data (b_q)
   );

   sbs_fifo #(
      .WIDTH (CmdW),
      .DEPTH (CmdDepth)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wdata),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rdata),
      .empty     (cmd_empty)
   );

   sbs_back #(
      .MAX_GRANULES (MAX_GRANULES),
      .RANK_WIDTH   (RANK_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_rdata),
      .a_rd_addr (a_rd_addr),
      .b_rd_addr (b_rd_addr),
      .a_q       (a_q),
      .b_q       (b_q),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_item),
      .rsp_full  (rsp_full),
      .back_stat (back_stat)
   );

   sbs_fifo #(
      .WIDTH (RspW),
      .DEPTH (RspDepth)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_item),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head_bits),
      .empty     (rsp_empty)
   );

   assign rsp_head      = rsp_item_type'(rsp_head_bits);
   assign rsp_out_rank  = rsp_head.out_rank;
   assign rsp_out_word  = rsp_head.out_word;
   assign rsp_answer    = rsp_head.answer;
   assign rsp_empty_res = rsp_head.empty_res;
   assign rsp_overflow  = rsp_head.overflow;
   assign rsp_last      = rsp_head.last;

   ap_cmd_room : assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_full)
      else $error("run command pushed into a full command queue");

   ap_rsp_room : assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full result queue");

   ap_front_one_action : assert property (@(posedge clock) disable iff (reset)
      $onehot0({a_we, b_we, cmd_push}))
      else $error("front end did more than one thing with one request");

   ap_cmd_pop_valid : assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("merge engine popped an empty command queue");

endmodule

`default_nettype wire
